FILE: design/wrrq_pkg.sv
// ----------------------------------------------------------------------------
// wrrq_pkg
// Shared types and constants of the weighted round-robin queue block.
// ----------------------------------------------------------------------------
package wrrq_pkg;

  localparam int NUM_CLASSES_DEF = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_WEIGHT_REGS = 4;
  localparam int DATA_W          = 32;
  localparam int WEIGHT_W        = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CLASS_IN_W      = 3;
  localparam int CLASS_OUT_W     = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd1;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_CLASS = 3'd2,
    ST_FULL      = 3'd3,
    ST_NONE      = 3'd4
  } status_e;

  typedef struct packed {
    status_e                  status;
    logic [CLASS_OUT_W-1:0]   served_class;
    logic                     rd;
  } sched_resp_t;

endpackage

FILE: design/weighted_round_robin_queues_unit.sv
// ----------------------------------------------------------------------------
// weighted_round_robin_queues_unit
// Per-class FIFO queues sharing one RAM, served in weighted round robin.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries push, pop or peek
// transactions; each produces exactly one result transaction on the output
// channel (out_valid_o / out_stall_i): value, status and served class.
// Class selection and pointer update happen at the accept edge; the queue
// RAM read is clocked at that same edge into the read stage, and its data is
// loaded into the output register when it holds no stalled result.
// Throughput: one transaction per cycle while the output drains, bounded by
// the single RAM port and the read stage. If the receiver stalls, the output
// register holds its result and one further transaction may sit in the read
// stage; then in_stall_o rises. Weights are written through cfg_we_i /
// cfg_index_i / cfg_data_i while idle; the user must keep to this, the block
// does not enforce it. Reset empties all queues, sets every weight to 1 and
// restarts the round at class 0; no clearing pass is needed, ready at once.
// ----------------------------------------------------------------------------
module weighted_round_robin_queues_unit #(
  parameter  int NUM_CLASSES = wrrq_pkg::NUM_CLASSES_DEF,
  parameter  int QUEUE_DEPTH = wrrq_pkg::QUEUE_DEPTH_DEF,
  localparam int AW          = $clog2(NUM_CLASSES * QUEUE_DEPTH)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             operation_i,
  input  logic signed [wrrq_pkg::DATA_W-1:0]     item_value_i,
  input  logic [wrrq_pkg::CLASS_IN_W-1:0]        class_index_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [wrrq_pkg::DATA_W-1:0]     result_value_o,
  output logic [2:0]                             status_o,
  output logic [wrrq_pkg::CLASS_OUT_W-1:0]       served_class_o,
  input  logic                                   cfg_we_i,
  input  logic [wrrq_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [wrrq_pkg::WEIGHT_W-1:0]          cfg_data_i
);

  logic                              accept;
  logic                              s1_move;
  logic                              mem_we;
  logic                              mem_re;
  logic [AW-1:0]                     mem_addr;
  logic signed [wrrq_pkg::DATA_W-1:0] mem_rdata;
  wrrq_pkg::sched_resp_t             resp;

  logic                              s1_valid_q, s1_valid_d;
  wrrq_pkg::sched_resp_t             s1_resp_q;
  logic                              out_valid_q, out_valid_d;
  logic signed [wrrq_pkg::DATA_W-1:0] out_value_q;
  wrrq_pkg::status_e                 out_status_q;
  logic [wrrq_pkg::CLASS_OUT_W-1:0]  out_class_q;

  wrrq_sched #(
    .NUM_CLASSES (NUM_CLASSES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_sched (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .class_index_i (class_index_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mem_we_o      (mem_we),
    .mem_re_o      (mem_re),
    .mem_addr_o    (mem_addr),
    .resp_o        (resp)
  );

  wrrq_store #(
    .NUM_CLASSES (NUM_CLASSES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (item_value_i),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_move    = s1_valid_q && !(out_valid_q && out_stall_i);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_resp_q <= resp;
    end
    if (s1_move) begin
      out_value_q  <= s1_resp_q.rd ? mem_rdata : '0;
      out_status_q <= s1_resp_q.status;
      out_class_q  <= s1_resp_q.served_class;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign served_class_o = out_class_q;

`ifndef SYNTH
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free pipeline");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=>
      s1_valid_q && $stable(s1_resp_q.status) && $stable(s1_resp_q.rd))
    else $error("read stage lost while output stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != wrrq_pkg::ST_OK |->
      out_value_q == '0 && out_class_q == '0)
    else $error("error result carries data");
`endif

endmodule

FILE: design/wrrq_store.sv
// ----------------------------------------------------------------------------
// wrrq_store
// Queue storage: single-port synchronous RAM, read data registered.
// ----------------------------------------------------------------------------
module wrrq_store #(
  parameter  int NUM_CLASSES = wrrq_pkg::NUM_CLASSES_DEF,
  parameter  int QUEUE_DEPTH = wrrq_pkg::QUEUE_DEPTH_DEF,
  localparam int Words       = NUM_CLASSES * QUEUE_DEPTH,
  localparam int AW          = $clog2(Words)
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic                               re_i,
  input  logic [AW-1:0]                      addr_i,
  input  logic signed [wrrq_pkg::DATA_W-1:0] wdata_i,
  output logic signed [wrrq_pkg::DATA_W-1:0] rdata_o
);

  logic [wrrq_pkg::DATA_W-1:0] mem [Words];
  logic [wrrq_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/wrrq_sched.sv
// ----------------------------------------------------------------------------
// wrrq_sched
// Per-class pointers, fill counts and weights; round-robin class selection
// and queue RAM request generation for one transaction.
// ----------------------------------------------------------------------------
module wrrq_sched #(
  parameter  int NUM_CLASSES = wrrq_pkg::NUM_CLASSES_DEF,
  parameter  int QUEUE_DEPTH = wrrq_pkg::QUEUE_DEPTH_DEF,
  localparam int CW          = $clog2(NUM_CLASSES),
  localparam int PW          = $clog2(QUEUE_DEPTH),
  localparam int FW          = $clog2(QUEUE_DEPTH + 1),
  localparam int AW          = $clog2(NUM_CLASSES * QUEUE_DEPTH)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic [1:0]                             operation_i,
  input  logic [wrrq_pkg::CLASS_IN_W-1:0]        class_index_i,
  input  logic                                   cfg_we_i,
  input  logic [wrrq_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [wrrq_pkg::WEIGHT_W-1:0]          cfg_data_i,
  output logic                                   mem_we_o,
  output logic                                   mem_re_o,
  output logic [AW-1:0]                          mem_addr_o,
  output wrrq_pkg::sched_resp_t                  resp_o
);

  logic [PW-1:0]                 head_q   [NUM_CLASSES];
  logic [PW-1:0]                 tail_q   [NUM_CLASSES];
  logic [FW-1:0]                 fill_q   [NUM_CLASSES];
  logic [wrrq_pkg::WEIGHT_W-1:0] weight_q [NUM_CLASSES];
  logic [CW-1:0]                 current_q;
  logic [wrrq_pkg::WEIGHT_W-1:0] served_q;

  wrrq_pkg::op_e     op;
  wrrq_pkg::status_e sel_status;
  wrrq_pkg::status_e status;
  logic [NUM_CLASSES-1:0] elig;
  logic              any;
  logic              cur_ok;
  logic              found;
  logic [CW-1:0]     found_cls;
  logic [CW+1:0]     wrap;
  logic [CW-1:0]     pick_cls;
  logic [wrrq_pkg::WEIGHT_W-1:0] pick_cnt;
  logic              is_push;
  logic              cidx_bad;
  logic [CW-1:0]     acc_cls;
  logic [PW-1:0]     head_sel;
  logic [PW-1:0]     tail_sel;
  logic [FW-1:0]     fill_sel;
  logic              push_ok;
  logic              pop_ok;
  logic              rd;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    next_slot = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    op       = wrrq_pkg::op_e'(operation_i);
    is_push  = (op == wrrq_pkg::OP_PUSH);
    cidx_bad = {1'b0, class_index_i} >= (wrrq_pkg::CLASS_IN_W + 1)'(NUM_CLASSES);

    any = 1'b0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      elig[k] = (weight_q[k] != '0) && (fill_q[k] != '0);
      any     = any | (fill_q[k] != '0);
    end
    cur_ok = (served_q < weight_q[current_q]) && (fill_q[current_q] != '0);

    found     = 1'b0;
    found_cls = '0;
    for (int i = NUM_CLASSES; i >= 1; i--) begin
      wrap = {2'b00, current_q} + (CW + 2)'(i);
      if (wrap >= (CW + 2)'(NUM_CLASSES)) begin
        wrap = wrap - (CW + 2)'(NUM_CLASSES);
      end
      if (elig[wrap[CW-1:0]]) begin
        found     = 1'b1;
        found_cls = wrap[CW-1:0];
      end
    end

    pick_cls = cur_ok ? current_q : found_cls;
    pick_cnt = cur_ok ? served_q : '0;
    if (!any) begin
      sel_status = wrrq_pkg::ST_EMPTY;
    end else if (cur_ok || found) begin
      sel_status = wrrq_pkg::ST_OK;
    end else begin
      sel_status = wrrq_pkg::ST_NONE;
    end

    acc_cls  = is_push ? class_index_i[CW-1:0] : pick_cls;
    head_sel = head_q[acc_cls];
    tail_sel = tail_q[acc_cls];
    fill_sel = fill_q[acc_cls];

    push_ok = 1'b0;
    pop_ok  = 1'b0;
    rd      = 1'b0;
    status  = wrrq_pkg::ST_OK;
    unique case (op)
      wrrq_pkg::OP_PUSH: begin
        if (cidx_bad) begin
          status = wrrq_pkg::ST_BAD_CLASS;
        end else if (fill_sel >= FW'(QUEUE_DEPTH)) begin
          status = wrrq_pkg::ST_FULL;
        end else begin
          push_ok = 1'b1;
        end
      end
      wrrq_pkg::OP_POP, wrrq_pkg::OP_PEEK: begin
        status = sel_status;
        rd     = (sel_status == wrrq_pkg::ST_OK);
        pop_ok = rd && (op == wrrq_pkg::OP_POP);
      end
      default: status = wrrq_pkg::ST_OK;
    endcase
  end

  assign mem_we_o   = accept_i && push_ok;
  assign mem_re_o   = accept_i && rd;
  assign mem_addr_o = AW'(acc_cls) * AW'(QUEUE_DEPTH) + AW'(is_push ? tail_sel : head_sel);

  assign resp_o.status       = status;
  assign resp_o.served_class = rd ? wrrq_pkg::CLASS_OUT_W'(pick_cls) : '0;
  assign resp_o.rd           = rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        head_q[k]   <= '0;
        tail_q[k]   <= '0;
        fill_q[k]   <= '0;
        weight_q[k] <= wrrq_pkg::WEIGHT_RESET;
      end
      current_q <= '0;
      served_q  <= '0;
    end else begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        if (k < wrrq_pkg::NUM_WEIGHT_REGS && cfg_we_i &&
            cfg_index_i == wrrq_pkg::CFG_IDX_W'(k)) begin
          weight_q[k] <= cfg_data_i;
        end
      end
      if (accept_i && push_ok) begin
        tail_q[acc_cls] <= next_slot(tail_sel);
        fill_q[acc_cls] <= fill_sel + 1'b1;
      end
      if (accept_i && pop_ok) begin
        head_q[acc_cls] <= next_slot(head_sel);
        fill_q[acc_cls] <= fill_sel - 1'b1;
        current_q       <= pick_cls;
        served_q        <= pick_cnt + 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_sel <= FW'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_current_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, current_q} < (CW + 1)'(NUM_CLASSES))
    else $error("current class out of range");

  a_served_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && pop_ok |=> served_q != '0)
    else $error("served count zero after pop");
`endif

endmodule
